// ----- hdl/snp_pkg.sv -----
package snp_pkg;

  // Field widths of the item and result channels.
  localparam int OP_W       = 3;
  localparam int RULE_IDX_W = 5;
  localparam int NEUR_IDX_W = 4;
  localparam int VAL_W      = 16;
  localparam int VEC_W      = 32;
  localparam int CNT_W      = 15;

  // Configuration register and port widths.
  localparam int NEUR_CFG_W = 5;
  localparam int RULE_CFG_W = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Default sizes.
  localparam int DEF_MAX_NEURONS = 16;
  localparam int DEF_MAX_RULES   = 32;

  // Group size of the first level of the gain adder tree.
  localparam int SUM_GROUP = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_GAIN  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RULE  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_SPIKE = 3'd2;
  localparam logic [OP_W-1:0] OP_FORWARD    = 3'd3;
  localparam logic [OP_W-1:0] OP_BACKWARD   = 3'd4;

  // Register indexes.
  localparam logic REG_NEURONS = 1'b0;
  localparam logic REG_RULES   = 1'b1;

  // Gain multiplier per rule: zero, one or two contributions.
  localparam logic [1:0] MULT_ZERO = 2'd0;
  localparam logic [1:0] MULT_ONE  = 2'd1;
  localparam logic [1:0] MULT_TWO  = 2'd2;

  // Write controls that the sequencer sends to each rule lane.
  typedef struct packed {
    logic             gain_we;
    logic             info_we;
    logic [VAL_W-1:0] gain_data;
    logic [NEUR_IDX_W-1:0] owner;
    logic [CNT_W-1:0] delay;
  } lane_wr_t;

endpackage

// ----- hdl/snp_if.sv -----
interface snp_in_if import snp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [RULE_IDX_W-1:0]  rule_index;
  logic [NEUR_IDX_W-1:0]  neuron_index;
  logic signed [VAL_W-1:0] load_value;
  logic [VEC_W-1:0]       chosen_rules;
  logic [VEC_W-1:0]       injected_rules;
  logic [VEC_W-1:0]       earlier_pending;

  modport source (output valid, operation, rule_index, neuron_index, load_value,
                  chosen_rules, injected_rules, earlier_pending, input ready);
  modport sink (input valid, operation, rule_index, neuron_index, load_value,
                chosen_rules, injected_rules, earlier_pending, output ready);
endinterface

interface snp_out_if import snp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NEUR_IDX_W-1:0]   neuron_id;
  logic signed [VAL_W-1:0] spike_total;
  logic [CNT_W-1:0]        countdown;
  logic                    fires;
  logic                    neuron_changed;
  logic                    synapse_changed;
  logic                    last_neuron;

  modport source (output valid, neuron_id, spike_total, countdown, fires,
                  neuron_changed, synapse_changed, last_neuron, input ready);
  modport sink (input valid, neuron_id, spike_total, countdown, fires,
                neuron_changed, synapse_changed, last_neuron, output ready);
endinterface

// ----- hdl/snp_lane.sv -----
module snp_lane import snp_pkg::*; #(
  parameter int MAX_NEURONS = DEF_MAX_NEURONS,
  localparam int NIW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lane_wr_t              wr,
  input  logic [NIW-1:0]        waddr,
  input  logic [NIW-1:0]        raddr,
  input  logic [1:0]            mult,
  output logic [NEUR_IDX_W-1:0] owner,
  output logic [CNT_W-1:0]      rdelay,
  output logic [VAL_W-1:0]      prod
);

  logic [VAL_W-1:0]      gain_mem [MAX_NEURONS];
  logic [VAL_W-1:0]      gain_q_r;
  logic [VAL_W-1:0]      prod_r;
  logic [NEUR_IDX_W-1:0] owner_r;
  logic [CNT_W-1:0]      rdelay_r;

  // One column of the gain matrix: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr.gain_we) begin
      gain_mem[waddr] <= wr.gain_data;
    end
    gain_q_r <= gain_mem[raddr];
  end

  // Gain scaled by the rule's count of contributions, wrapping at 16 bits.
  always_ff @(posedge clk) begin
    case (mult)
      MULT_ZERO: prod_r <= '0;
      MULT_ONE:  prod_r <= gain_q_r;
      MULT_TWO:  prod_r <= {gain_q_r[VAL_W-2:0], 1'b0};
      default:   prod_r <= '0;
    endcase
  end

  // Owner neuron and delay of this rule.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r  <= '0;
      rdelay_r <= '0;
    end else if (wr.info_we) begin
      owner_r  <= wr.owner;
      rdelay_r <= wr.delay;
    end
  end

  assign owner  = owner_r;
  assign rdelay = rdelay_r;
  assign prod   = prod_r;

endmodule

// ----- hdl/snp_merge.sv -----
module snp_merge import snp_pkg::*; #(
  parameter int MAX_RULES = DEF_MAX_RULES
) (
  input  logic             clk,
  input  logic [VAL_W-1:0] prod [MAX_RULES],
  output logic [VAL_W-1:0] gain_sum
);

  localparam int NG = (MAX_RULES + SUM_GROUP - 1) / SUM_GROUP;

  logic [VAL_W-1:0] group_r [NG];

  // First tree level: registered sums of groups of lanes.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      logic [VAL_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < SUM_GROUP; k++) begin
        if (g * SUM_GROUP + k < MAX_RULES) begin
          acc = acc + prod[g * SUM_GROUP + k];
        end
      end
      group_r[g] <= acc;
    end
  end

  // Second level: sum of the group totals.
  always_comb begin
    gain_sum = '0;
    for (int g = 0; g < NG; g++) begin
      gain_sum = gain_sum + group_r[g];
    end
  end

endmodule

// ----- hdl/snp_system_matrix_step_core.sv -----
// Spiking neural P system stepper in matrix form.
// Items arrive on in_item (valid/ready). Operations load a gain entry, a rule's
// owner and delay, or a neuron's spike count; these finish in the cycle the item
// is accepted and give no result. A forward or backward step gives one result
// per neuron in use on out_item, in neuron order, last_neuron on the final one.
// Steps: a forward step updates the neuron delays and evaluates the rules; a
// backward step only evaluates the rules. Each then takes every neuron through
// gain read, scaling, group sum, and final sum and update, states set by the
// one-row gain read and the two-level adder tree that merges the rule lanes.
// A new item is taken once the last result is loaded.
// After reset a clearing pass over every neuron index zeroes the gain memories;
// no item is accepted during it, configuration writes are.
// The result register holds while out_item.ready is low, and the sequencer
// waits on the final update of a neuron until the register is free.
// Registers over cfg_*: neurons_in_use at 0x0, rules_in_use at 0x4.
module snp_system_matrix_step_core import snp_pkg::*; #(
  parameter int MAX_NEURONS = DEF_MAX_NEURONS,
  parameter int MAX_RULES   = DEF_MAX_RULES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  snp_in_if.sink                in_item,
  snp_out_if.source             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NIW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int NCW = $clog2(MAX_NEURONS + 1);
  localparam int RCW = $clog2(MAX_RULES + 1);

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_DLY  = 8'b00000100,
    S_IND  = 8'b00001000,
    S_RD   = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_SUM  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [NCW-1:0] idx_r, idx_nxt;
  logic [NIW-1:0] nidx;

  logic [NEUR_CFG_W-1:0] cfg_neurons_r;
  logic [RULE_CFG_W-1:0] cfg_rules_r;
  logic [NCW-1:0]        nn;
  logic [RCW-1:0]        nr;

  logic                 fwd_r;
  logic [MAX_RULES-1:0] chosen_r, inj_r, epend_r;
  logic [MAX_RULES-1:0] pend_r, ind_r, rule_mask;
  logic [MAX_RULES-1:0] ind_c, pend_fwd_c;

  logic signed [VAL_W-1:0] spike_r [MAX_NEURONS];
  logic [CNT_W-1:0]        delay_r [MAX_NEURONS];
  logic [MAX_NEURONS-1:0]  flag_r, nchg_r, dz;

  lane_wr_t              lane_wr [MAX_RULES];
  logic [NIW-1:0]        lane_waddr;
  logic [1:0]            lane_mult [MAX_RULES];
  logic [NEUR_IDX_W-1:0] owner [MAX_RULES];
  logic [CNT_W-1:0]      rdelay [MAX_RULES];
  logic [VAL_W-1:0]      prod [MAX_RULES];
  logic [VAL_W-1:0]      gain_sum;

  logic                    out_valid_r;
  logic [NEUR_IDX_W-1:0]   out_id_r;
  logic signed [VAL_W-1:0] out_spike_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_fire_r, out_nchg_r, out_schg_r, out_last_r;

  logic in_acc, out_free, fin_go;
  logic [CNT_W-1:0] dly_first, dly_new;
  logic fire_c, ep_match;
  logic signed [VAL_W-1:0] spike_new;
  logic spk_upd;
  logic [CNT_W-1:0] cnt_new;
  logic nchg_new, schg_new;

  assign nidx = idx_r[NIW-1:0];

  // Configuration port.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_neurons_r <= NEUR_CFG_W'(DEF_MAX_NEURONS);
      cfg_rules_r   <= RULE_CFG_W'(DEF_MAX_RULES);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_NEURONS: cfg_neurons_r <= cfg_pwdata[NEUR_CFG_W-1:0];
        REG_RULES:   cfg_rules_r   <= cfg_pwdata[RULE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_NEURONS: cfg_prdata = CFG_DATA_W'(cfg_neurons_r);
      REG_RULES:   cfg_prdata = CFG_DATA_W'(cfg_rules_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // Effective counts, clamped to the built sizes.
  always_comb begin
    if (int'(cfg_neurons_r) > MAX_NEURONS) nn = NCW'(MAX_NEURONS);
    else nn = NCW'(cfg_neurons_r);
    if (int'(cfg_rules_r) > MAX_RULES) nr = RCW'(MAX_RULES);
    else nr = RCW'(cfg_rules_r);
    for (int r = 0; r < MAX_RULES; r++) begin
      rule_mask[r] = RCW'(r) < nr;
    end
  end

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;
  assign fin_go        = (state_r == S_FIN) && out_free;

  // Write controls for the rule lanes: loads, and the clearing pass.
  always_comb begin
    lane_waddr = (state_r == S_CLR) ? nidx : NIW'(in_item.neuron_index);
    for (int r = 0; r < MAX_RULES; r++) begin
      lane_wr[r].gain_data = (state_r == S_CLR) ? '0 : in_item.load_value;
      lane_wr[r].owner     = in_item.neuron_index;
      lane_wr[r].delay     = in_item.load_value[CNT_W-1:0];
      lane_wr[r].gain_we   = (state_r == S_CLR) ||
                             (in_acc && in_item.operation == OP_LOAD_GAIN &&
                              int'(in_item.rule_index) == r &&
                              int'(in_item.neuron_index) < MAX_NEURONS);
      lane_wr[r].info_we   = in_acc && in_item.operation == OP_LOAD_RULE &&
                             int'(in_item.rule_index) == r;
      lane_mult[r] = {1'b0, ind_r[r]} + {1'b0, inj_r[r] & rule_mask[r]};
    end
  end

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_lane
    snp_lane #(.MAX_NEURONS(MAX_NEURONS)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (lane_wr[g]),
      .waddr  (lane_waddr),
      .raddr  (nidx),
      .mult   (lane_mult[g]),
      .owner  (owner[g]),
      .rdelay (rdelay[g]),
      .prod   (prod[g])
    );
  end

  snp_merge #(.MAX_RULES(MAX_RULES)) u_merge (
    .clk      (clk),
    .prod     (prod),
    .gain_sum (gain_sum)
  );

  // Forward delay update: first chosen rule owned by the current neuron.
  always_comb begin
    dly_first = '0;
    for (int r = MAX_RULES - 1; r >= 0; r--) begin
      if (rule_mask[r] && chosen_r[r] && int'(owner[r]) == int'(idx_r)) begin
        dly_first = rdelay[r];
      end
    end
    dly_new = (delay_r[nidx] != '0) ? delay_r[nidx] - CNT_W'(1) : dly_first;
  end

  // Applicability of every rule and the next pending bits.
  always_comb begin
    for (int n = 0; n < MAX_NEURONS; n++) begin
      dz[n] = (delay_r[n] == '0);
    end
    for (int r = 0; r < MAX_RULES; r++) begin
      logic pb;
      pb = fwd_r ? pend_r[r] : epend_r[r];
      ind_c[r] = rule_mask[r] && int'(owner[r]) < int'(nn) && dz[owner[r]] &&
                 ((chosen_r[r] && rdelay[r] == '0) || pb);
      pend_fwd_c[r] = rule_mask[r] ?
                      ((pend_r[r] && !ind_c[r]) || (chosen_r[r] && rdelay[r] != '0)) :
                      pend_r[r];
    end
  end

  // Per-neuron firing, backward countdown and the final update.
  always_comb begin
    fire_c   = 1'b0;
    ep_match = 1'b0;
    for (int r = 0; r < MAX_RULES; r++) begin
      if (rule_mask[r] && int'(owner[r]) == int'(idx_r)) begin
        fire_c   = fire_c | ind_r[r] | inj_r[r];
        ep_match = ep_match | epend_r[r];
      end
    end
    spk_upd = (delay_r[nidx] == '0) && (gain_sum != '0);
    if (fwd_r) begin
      spike_new = spk_upd ? spike_r[nidx] + signed'(gain_sum) : spike_r[nidx];
      cnt_new   = delay_r[nidx];
      nchg_new  = nchg_r[nidx] || spk_upd;
      schg_new  = fire_c != flag_r[nidx];
    end else begin
      spike_new = spk_upd ? spike_r[nidx] - signed'(gain_sum) : spike_r[nidx];
      cnt_new   = ep_match ? delay_r[nidx] + CNT_W'(1) : '0;
      nchg_new  = spk_upd || (cnt_new != delay_r[nidx]);
      schg_new  = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_CLR: begin
        idx_nxt = idx_r + NCW'(1);
        if (int'(idx_r) == MAX_NEURONS - 1) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc && in_item.operation == OP_FORWARD) state_nxt = S_DLY;
        if (in_acc && in_item.operation == OP_BACKWARD) state_nxt = S_IND;
      end
      S_DLY: begin
        if (idx_r >= nn) begin
          state_nxt = S_IND;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + NCW'(1);
        end
      end
      S_IND: state_nxt = (nn == '0) ? S_IDLE : S_RD;
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          if (idx_r + NCW'(1) >= nn) begin
            state_nxt = S_IDLE;
            idx_nxt   = '0;
          end else begin
            state_nxt = S_RD;
            idx_nxt   = idx_r + NCW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Step operands, held for the whole step.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_r <= in_item.operation == OP_FORWARD;
      for (int r = 0; r < MAX_RULES; r++) begin
        chosen_r[r] <= (r < VEC_W) ? in_item.chosen_rules[r] : 1'b0;
        inj_r[r]    <= (r < VEC_W) ? in_item.injected_rules[r] : 1'b0;
        epend_r[r]  <= (r < VEC_W) ? in_item.earlier_pending[r] : 1'b0;
      end
    end
  end

  // Neuron and rule state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < MAX_NEURONS; n++) begin
        spike_r[n] <= '0;
        delay_r[n] <= '0;
      end
      flag_r <= '0;
      nchg_r <= '0;
      pend_r <= '0;
      ind_r  <= '0;
    end else begin
      if (in_acc && in_item.operation == OP_LOAD_SPIKE &&
          int'(in_item.neuron_index) < MAX_NEURONS) begin
        spike_r[NIW'(in_item.neuron_index)] <= in_item.load_value;
      end
      if (state_r == S_DLY && idx_r < nn) begin
        delay_r[nidx] <= dly_new;
        nchg_r[nidx]  <= dly_new != delay_r[nidx];
      end
      if (state_r == S_IND) begin
        ind_r  <= ind_c;
        pend_r <= fwd_r ? pend_fwd_c : epend_r;
      end
      if (fin_go) begin
        spike_r[nidx] <= spike_new;
        delay_r[nidx] <= cnt_new;
        if (fwd_r) flag_r[nidx] <= fire_c;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_id_r    <= NEUR_IDX_W'(idx_r);
      out_spike_r <= spike_new;
      out_cnt_r   <= cnt_new;
      out_fire_r  <= fwd_r ? fire_c : flag_r[nidx];
      out_nchg_r  <= nchg_new;
      out_schg_r  <= schg_new;
      out_last_r  <= (idx_r + NCW'(1)) == nn;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.neuron_id       = out_id_r;
  assign out_item.spike_total     = out_spike_r;
  assign out_item.countdown       = out_cnt_r;
  assign out_item.fires           = out_fire_r;
  assign out_item.neuron_changed  = out_nchg_r;
  assign out_item.synapse_changed = out_schg_r;
  assign out_item.last_neuron     = out_last_r;

  // A new result appears only after a final neuron update.
  a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside the final update");

  // Rules beyond the ones in use are never applicable.
  a_ind_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (ind_r & ~rule_mask) == '0)
    else $error("unused rule marked applicable");

  // The neuron counter stays within the neurons in use while results are made.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> idx_r < nn)
    else $error("neuron counter out of range");

endmodule

// ----- tb/sv/snp_system_matrix_step_core_test.sv -----
`timescale 1ns / 100ps

module snp_system_matrix_step_core_test;
  import snp_pkg::*;

  localparam int NEUR_MAX = DEF_MAX_NEURONS;
  localparam int RULE_MAX = DEF_MAX_RULES;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [NEUR_IDX_W-1:0]   neuron_id;
    logic signed [VAL_W-1:0] spike_total;
    logic [CNT_W-1:0]        countdown;
    logic                    fires;
    logic                    neuron_changed;
    logic                    synapse_changed;
    logic                    last_neuron;
  } neuron_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  snp_in_if  in_item ();
  snp_out_if out_item ();

  snp_system_matrix_step_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item.sink),
    .out_item   (out_item.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow copy of the block state.
  logic [4:0]        sh_neurons;
  logic [5:0]        sh_rules;
  logic [VAL_W-1:0]  sh_spikes [NEUR_MAX];
  logic [CNT_W-1:0]  sh_delay_left [NEUR_MAX];
  logic              sh_firing [NEUR_MAX];
  logic [VEC_W-1:0]  sh_pending;
  logic [VAL_W-1:0]  sh_gain [NEUR_MAX][RULE_MAX];
  logic [CNT_W-1:0]  sh_rule_delay [RULE_MAX];
  logic [NEUR_IDX_W-1:0] sh_owner [RULE_MAX];

  neuron_result_t expected_results [$];
  int  error_count;
  int  cycle_count;
  bit  hold_off;
  int  hold_off_cycles;

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern, and for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_item.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (hold_off) begin
      out_item.ready <= 1'b0;
      hold_off_cycles <= 600;
      hold_off <= 1'b0;
    end else if (cycle_count[9:8] == 2'b11) begin
      out_item.ready <= 1'b1;
    end else begin
      out_item.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    neuron_result_t got;
    neuron_result_t want;
    if (rst_n && out_item.valid && out_item.ready) begin
      got = '{out_item.neuron_id, out_item.spike_total, out_item.countdown,
              out_item.fires, out_item.neuron_changed, out_item.synapse_changed,
              out_item.last_neuron};
      if (expected_results.size() == 0) begin
        $error("Result for neuron %0d arrived with nothing expected", got.neuron_id);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.neuron_id != want.neuron_id) begin
          $error("neuron_id: expected %0d, got %0d", want.neuron_id, got.neuron_id);
          error_count++;
        end
        if (got.spike_total != want.spike_total) begin
          $error("spike_total: expected %0d, got %0d", want.spike_total, got.spike_total);
          error_count++;
        end
        if (got.countdown != want.countdown) begin
          $error("countdown: expected %0d, got %0d", want.countdown, got.countdown);
          error_count++;
        end
        if (got.fires != want.fires) begin
          $error("fires: expected %0b, got %0b", want.fires, got.fires);
          error_count++;
        end
        if (got.neuron_changed != want.neuron_changed) begin
          $error("neuron_changed: expected %0b, got %0b", want.neuron_changed,
                 got.neuron_changed);
          error_count++;
        end
        if (got.synapse_changed != want.synapse_changed) begin
          $error("synapse_changed: expected %0b, got %0b", want.synapse_changed,
                 got.synapse_changed);
          error_count++;
        end
        if (got.last_neuron != want.last_neuron) begin
          $error("last_neuron: expected %0b, got %0b", want.last_neuron, got.last_neuron);
          error_count++;
        end
      end
    end
  end

  // Rules in use that may apply, given the current countdowns.
  function automatic logic [VEC_W-1:0] applicable_rules(int nn, int nr,
                                                       logic [VEC_W-1:0] chosen,
                                                       logic [VEC_W-1:0] pend);
    logic [VEC_W-1:0] app;
    app = '0;
    for (int r = 0; r < nr; r++) begin
      if (sh_owner[r] < nn && sh_delay_left[sh_owner[r]] == 0) begin
        app[r] = (chosen[r] && sh_rule_delay[r] == 0) || pend[r];
      end
    end
    return app;
  endfunction

  // Net gain of one neuron, wrapping at 16 bits.
  function automatic logic [VAL_W-1:0] neuron_gain(int n, int nr, logic [VEC_W-1:0] app,
                                                   logic [VEC_W-1:0] inj);
    logic [VAL_W-1:0] sum;
    sum = '0;
    for (int r = 0; r < nr; r++) begin
      sum += VAL_W'(int'(app[r]) + int'(inj[r])) * sh_gain[n][r];
    end
    return sum;
  endfunction

  // Apply one item to the shadow state and queue its results.
  task automatic predict_item(logic [OP_W-1:0] op, logic [4:0] ri, logic [3:0] ni,
                              logic [VAL_W-1:0] lv, logic [VEC_W-1:0] chosen,
                              logic [VEC_W-1:0] inj, logic [VEC_W-1:0] epend);
    int nn;
    int nr;
    logic [VEC_W-1:0] app;
    logic [VAL_W-1:0] g;
    logic [CNT_W-1:0] d;
    logic [CNT_W-1:0] nw;
    logic f;
    bit found;
    logic nchg [NEUR_MAX];
    logic schg [NEUR_MAX];
    neuron_result_t res;
    nn = (sh_neurons > NEUR_MAX) ? NEUR_MAX : sh_neurons;
    nr = (sh_rules > RULE_MAX) ? RULE_MAX : sh_rules;
    case (op)
      OP_LOAD_GAIN: begin
        sh_gain[ni][ri] = lv;
        return;
      end
      OP_LOAD_RULE: begin
        sh_owner[ri] = ni;
        sh_rule_delay[ri] = lv[CNT_W-1:0];
        return;
      end
      OP_LOAD_SPIKE: begin
        sh_spikes[ni] = lv;
        return;
      end
      OP_FORWARD: begin
        for (int i = 0; i < nn; i++) begin
          d = '0;
          for (int r = 0; r < nr; r++) begin
            if (sh_owner[r] == i && chosen[r]) begin
              d = sh_rule_delay[r];
              break;
            end
          end
          nw = (sh_delay_left[i] > 0) ? sh_delay_left[i] - 1'b1 : d;
          nchg[i] = (nw != sh_delay_left[i]);
          sh_delay_left[i] = nw;
        end
        app = applicable_rules(nn, nr, chosen, sh_pending);
        for (int i = 0; i < nn; i++) begin
          f = 1'b0;
          for (int r = 0; r < nr; r++) begin
            if (sh_owner[r] == i && (app[r] || inj[r])) f = 1'b1;
          end
          schg[i] = (f != sh_firing[i]);
          sh_firing[i] = f;
        end
        for (int i = 0; i < nn; i++) begin
          g = neuron_gain(i, nr, app, inj);
          if (sh_delay_left[i] == 0 && g != 0) begin
            nchg[i] = 1'b1;
            sh_spikes[i] = sh_spikes[i] + g;
          end
        end
        for (int r = 0; r < nr; r++) begin
          sh_pending[r] = (sh_pending[r] && !app[r]) || (chosen[r] && sh_rule_delay[r] > 0);
        end
      end
      OP_BACKWARD: begin
        app = applicable_rules(nn, nr, chosen, epend);
        for (int i = 0; i < nn; i++) begin
          g = neuron_gain(i, nr, app, inj);
          nchg[i] = 1'b0;
          schg[i] = 1'b0;
          if (sh_delay_left[i] == 0 && g != 0) begin
            nchg[i] = 1'b1;
            sh_spikes[i] = sh_spikes[i] - g;
          end
          found = 1'b0;
          for (int r = 0; r < nr; r++) begin
            if (sh_owner[r] == i && epend[r]) found = 1'b1;
          end
          nw = found ? sh_delay_left[i] + 1'b1 : '0;
          if (nw != sh_delay_left[i]) nchg[i] = 1'b1;
          sh_delay_left[i] = nw;
        end
        sh_pending = epend;
      end
      default: begin
        return;
      end
    endcase
    for (int i = 0; i < nn; i++) begin
      res.neuron_id       = i[3:0];
      res.spike_total     = sh_spikes[i];
      res.countdown       = sh_delay_left[i];
      res.fires           = sh_firing[i];
      res.neuron_changed  = nchg[i];
      res.synapse_changed = schg[i];
      res.last_neuron     = (i + 1 == nn);
      expected_results.push_back(res);
    end
  endtask

  // Send one item, wait for it to be taken and predict its results.
  task automatic send_item(logic [OP_W-1:0] op, logic [4:0] ri, logic [3:0] ni,
                           logic [VAL_W-1:0] lv, logic [VEC_W-1:0] chosen,
                           logic [VEC_W-1:0] inj, logic [VEC_W-1:0] epend);
    in_item.valid           <= 1'b1;
    in_item.operation       <= op;
    in_item.rule_index      <= ri;
    in_item.neuron_index    <= ni;
    in_item.load_value      <= lv;
    in_item.chosen_rules    <= chosen;
    in_item.injected_rules  <= inj;
    in_item.earlier_pending <= epend;
    do @(posedge clk); while (!in_item.ready);
    predict_item(op, ri, ni, lv, chosen, inj, epend);
  endtask

  task automatic drop_valid();
    in_item.valid <= 1'b0;
  endtask

  // Gap of random length between bursts, or none.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(logic index, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(index) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (index == REG_NEURONS) sh_neurons = value[4:0];
    else sh_rules = value[5:0];
  endtask

  // Wait until the block is idle, then set both registers.
  task automatic set_sizes(logic [CFG_DATA_W-1:0] neurons, logic [CFG_DATA_W-1:0] rules);
    drop_valid();
    wait_idle();
    write_register(REG_NEURONS, neurons);
    write_register(REG_RULES, rules);
  endtask

  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [VEC_W-1:0] rand_vec();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Gains, rule info and spike counts with small values in the main.
  task automatic load_system(int count);
    logic [VAL_W-1:0] v;
    for (int k = 0; k < count; k++) begin
      v = ($urandom_range(0, 7) == 0) ? VAL_W'($urandom()) : VAL_W'($urandom_range(0, 6) - 3);
      case ($urandom_range(0, 2))
        0: send_item(OP_LOAD_GAIN, 5'($urandom()), 4'($urandom()), v, rand_vec(), rand_vec(),
                     rand_vec());
        1: send_item(OP_LOAD_RULE, 5'($urandom()), 4'($urandom()),
                     ($urandom_range(0, 9) == 0) ? VAL_W'($urandom()) : VAL_W'($urandom_range(0, 3)),
                     rand_vec(), rand_vec(), rand_vec());
        default: send_item(OP_LOAD_SPIKE, 5'($urandom()), 4'($urandom()), v, rand_vec(),
                           rand_vec(), rand_vec());
      endcase
      sender_gap();
    end
  endtask

  // Directed: field extremes, every operation and the special cases.
  task automatic test_directed();
    send_item(OP_LOAD_GAIN, 5'd0, 4'd0, 16'h7FFF, '0, '0, '0);
    send_item(OP_LOAD_GAIN, 5'd31, 4'd15, 16'h8000, '1, '1, '1);
    send_item(OP_LOAD_GAIN, 5'd1, 4'd1, 16'hFFFF, '0, '0, '0);
    send_item(OP_LOAD_RULE, 5'd0, 4'd0, 16'd0, '0, '0, '0);
    send_item(OP_LOAD_RULE, 5'd31, 4'd15, 16'hFFFF, '0, '0, '0);
    send_item(OP_LOAD_RULE, 5'd1, 4'd1, 16'd2, '0, '0, '0);
    send_item(OP_LOAD_SPIKE, 5'd0, 4'd0, 16'h7FFF, '0, '0, '0);
    send_item(OP_LOAD_SPIKE, 5'd0, 4'd15, 16'h8000, '0, '0, '0);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, 32'h3, 32'h8000_0001, '0);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, '0, '0, '0);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, '1, '1, '0);
    send_item(OP_BACKWARD, 5'd0, 4'd0, 16'd0, 32'h3, 32'h1, 32'h8000_0002);
    send_item(OP_BACKWARD, 5'd0, 4'd0, 16'd0, '1, '1, '1);
    send_item(OP_BACKWARD, 5'd0, 4'd0, 16'd0, '0, '0, '0);
    // Unused operation codes do nothing.
    send_item(3'd5, 5'd3, 4'd3, 16'h1234, '1, '1, '1);
    send_item(3'd6, 5'd3, 4'd3, 16'h1234, '1, '1, '1);
    send_item(3'd7, 5'd3, 4'd3, 16'h1234, '1, '1, '1);
    // Rule owned by a neuron beyond those in use.
    set_sizes(4, 8);
    send_item(OP_LOAD_RULE, 5'd2, 4'd9, 16'd0, '0, '0, '0);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, 32'hFF, 32'h0F0, '0);
    // No neuron or rule in use: the step gives no result.
    set_sizes(0, 0);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, '1, '1, '0);
    set_sizes(31, 63);
    send_item(OP_FORWARD, 5'd0, 4'd0, 16'd0, '1, '1, '0);
    drop_valid();
  endtask

  // Random load and step sequences at one size setting.
  task automatic test_random_steps(int steps, bit long_stall);
    int sent;
    sent = 0;
    load_system(12);
    if (long_stall) hold_off <= 1'b1;
    while (sent < steps) begin
      if ($urandom_range(0, 4) == 0) load_system($urandom_range(1, 4));
      send_item($urandom_range(0, 2) != 0 ? OP_FORWARD : OP_BACKWARD, 5'($urandom()),
                4'($urandom()), VAL_W'($urandom()), rand_vec(), rand_vec(), rand_vec());
      sent++;
      sender_gap();
    end
    drop_valid();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    hold_off_cycles = 0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_item.valid = 1'b0;
    in_item.operation = '0;
    in_item.rule_index = '0;
    in_item.neuron_index = '0;
    in_item.load_value = '0;
    in_item.chosen_rules = '0;
    in_item.injected_rules = '0;
    in_item.earlier_pending = '0;
    out_item.ready = 1'b0;
    sh_neurons = 5'd16;
    sh_rules = 6'd32;
    sh_pending = '0;
    for (int i = 0; i < NEUR_MAX; i++) begin
      sh_spikes[i] = '0;
      sh_delay_left[i] = '0;
      sh_firing[i] = 1'b0;
      for (int r = 0; r < RULE_MAX; r++) sh_gain[i][r] = '0;
    end
    for (int r = 0; r < RULE_MAX; r++) begin
      sh_rule_delay[r] = '0;
      sh_owner[r] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_sizes(16, 32);
    test_random_steps(50, 1'b1);
    set_sizes(1, 1);
    test_random_steps(40, 1'b0);
    set_sizes(5, 12);
    test_random_steps(50, 1'b0);
    set_sizes(16, 7);
    test_random_steps(40, 1'b0);
    set_sizes(9, 32);
    test_random_steps(50, 1'b0);

    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- snp_system_matrix_step_core.f -----
hdl/snp_pkg.sv
hdl/snp_if.sv
hdl/snp_lane.sv
hdl/snp_merge.sv
hdl/snp_system_matrix_step_core.sv
tb/sv/snp_system_matrix_step_core_test.sv
